@@ sv/stroke_fixed_step_resampler_assert.svh @@
// Assertion macros for the stroke resampler checker.
`ifndef STROKE_FIXED_STEP_RESAMPLER_ASSERT_SVH
`define STROKE_FIXED_STEP_RESAMPLER_ASSERT_SVH
// Implication that must hold in the same cycle.
`define SFSR_ASSERT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) else $error(msg);
// Implication that must hold in the following cycle.
`define SFSR_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`endif

@@ sv/sfsr_pkg.sv @@
// Package with the request and response types and codes of the stroke resampler.
`timescale 1ns / 1ps
package sfsr_pkg;
  localparam int unsigned MaxStepsDefault = 62;
  localparam int unsigned CoordW = 28;
  localparam int unsigned SpacingW = 20;
  localparam logic [SpacingW-1:0] SpacingReset = 20'd1600;
  localparam logic [SpacingW-1:0] SpacingMin = 20'd160;

  localparam logic [1:0] ModePress = 2'd0;
  localparam logic [1:0] ModeDrag = 2'd1;
  localparam logic [1:0] ModeRelease = 2'd2;
  localparam logic [1:0] ModeAbort = 2'd3;

  localparam logic [1:0] KindPoint = 2'd0;
  localparam logic [1:0] KindComplete = 2'd1;
  localparam logic [1:0] KindReject = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
  } req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
    logic last_of_run;
  } rsp_t;
endpackage

@@ sv/stroke_fixed_step_resampler.sv @@
// Stroke resampler: bit-serial square root and division, one result register.
// Press: accept, then the first point from the result register. Drag or release: accept, the
// squares and the bit-serial square root, then per emitted point a check, a multiply, a
// 59-step division and the emit, and one final check; a release adds the endpoint and the
// verdict. One request at a time; output stalls hold every state that loads a result.
// Reset clears all control state; spacing returns to 1600.
`timescale 1ns / 1ps
module stroke_fixed_step_resampler #(
  parameter int unsigned MaxSteps = sfsr_pkg::MaxStepsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sfsr_pkg::req_t                in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sfsr_pkg::rsp_t                out_rsp_o,
  input  logic                          cfg_we_i,
  input  logic [sfsr_pkg::SpacingW-1:0] cfg_wdata_i
);
  localparam int unsigned CW = sfsr_pkg::CoordW;
  localparam int unsigned DW = CW + 1;
  localparam int unsigned SumW = 2 * DW;
  localparam int unsigned LenW = DW;
  localparam int unsigned DistW = LenW + 1;
  localparam int unsigned ProdW = DW + DistW;
  localparam int unsigned KW = $clog2(MaxSteps + 1);
  localparam int unsigned CntW = $clog2(ProdW + 1);

  typedef enum logic [3:0] {
    StIdle, StFirst, StSquare, StRoot, StCheck, StMul, StDiv, StEmit, StEnd, StVerdict
  } state_e;

  state_e state_q;
  logic [sfsr_pkg::SpacingW-1:0] spacing_q, sp_eff;
  logic active_q, rel_q;
  logic [1:0] pts_q;
  logic signed [CW-1:0] pt_q [3];
  logic signed [CW-1:0] base_q [3];
  logic signed [CW-1:0] anchor_q [3];
  logic signed [DW-1:0] d_q [3];
  logic [SumW-1:0] acc_q, prod_q, sqv_q;
  logic [LenW-1:0] root_q, len_q;
  logic [LenW+1:0] rem_q;
  logic [DistW-1:0] dist_q;
  logic [KW-1:0] k_q;
  logic [CntW-1:0] cnt_q;
  logic [ProdW-1:0] num_q [3];
  logic [LenW-1:0] drem_q [3];
  logic [DistW-1:0] quo_q [3];
  logic out_valid_q;
  sfsr_pkg::rsp_t out_q;

  logic out_free;
  logic out_load;
  logic end_same;
  logic [1:0] sq_idx;
  logic signed [SumW-1:0] sq_prod;
  logic [LenW+3:0] rt_t, rt_trial;
  logic [LenW-1:0] root_d;
  logic [DistW:0] dist_next;
  logic more_steps;
  logic [CW-1:0] interp [3];
  logic [DW-1:0] mag [3];

  assign sp_eff = (spacing_q < sfsr_pkg::SpacingMin) ? sfsr_pkg::SpacingMin : spacing_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o = out_q;
  assign end_same = (pt_q[0] == anchor_q[0]) && (pt_q[1] == anchor_q[1])
                    && (pt_q[2] == anchor_q[2]);

  always_comb begin
    case (state_q)
      StFirst, StEmit, StVerdict: out_load = out_free;
      StEnd: out_load = out_free && !end_same;
      default: out_load = 1'b0;
    endcase
  end

  assign sq_idx = (cnt_q[1:0] == 2'd3) ? 2'd2 : cnt_q[1:0];
  assign sq_prod = d_q[sq_idx] * d_q[sq_idx];
  assign rt_t = {rem_q, sqv_q[SumW-1 -: 2]};
  assign rt_trial = {2'b00, root_q, 2'b01};
  assign root_d = (rt_t >= rt_trial) ? {root_q[LenW-2:0], 1'b1} : {root_q[LenW-2:0], 1'b0};
  assign dist_next = {1'b0, dist_q} + (DistW+1)'(sp_eff);
  assign more_steps = ((KW+1)'(k_q) + (KW+1)'(1) < (KW+1)'(MaxSteps))
                      && (dist_next <= (DistW+1)'(len_q));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [CW+2:0] qv;
      logic signed [CW+2:0] sum;
      mag[i] = d_q[i][DW-1] ? DW'(-d_q[i]) : DW'(d_q[i]);
      qv = $signed({1'b0, quo_q[i]});
      sum = (CW+3)'(base_q[i]) + (d_q[i][DW-1] ? -qv : qv);
      interp[i] = sum[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      spacing_q <= sfsr_pkg::SpacingReset;
      active_q <= 1'b0;
      rel_q <= 1'b0;
      pts_q <= 2'd0;
      out_valid_q <= 1'b0;
      k_q <= '0;
      cnt_q <= '0;
      for (int i = 0; i < 3; i++) begin
        anchor_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        spacing_q <= cfg_wdata_i;
      end
      if (out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            pt_q[0] <= in_req_i.point_x;
            pt_q[1] <= in_req_i.point_y;
            pt_q[2] <= in_req_i.point_z;
            d_q[0] <= DW'(in_req_i.point_x) - DW'(anchor_q[0]);
            d_q[1] <= DW'(in_req_i.point_y) - DW'(anchor_q[1]);
            d_q[2] <= DW'(in_req_i.point_z) - DW'(anchor_q[2]);
            for (int i = 0; i < 3; i++) begin
              base_q[i] <= anchor_q[i];
            end
            rel_q <= (in_req_i.mode == sfsr_pkg::ModeRelease);
            cnt_q <= '0;
            case (in_req_i.mode)
              sfsr_pkg::ModePress: begin
                if (!active_q) begin
                  active_q <= 1'b1;
                  state_q <= StFirst;
                end
              end
              sfsr_pkg::ModeDrag: begin
                if (active_q) begin
                  state_q <= StSquare;
                end
              end
              sfsr_pkg::ModeRelease: begin
                if (active_q) begin
                  active_q <= 1'b0;
                  state_q <= StSquare;
                end
              end
              default: begin
                active_q <= 1'b0;
                pts_q <= 2'd0;
              end
            endcase
          end
        end
        StFirst: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_q <= '{kind: sfsr_pkg::KindPoint, out_x: pt_q[0], out_y: pt_q[1],
                       out_z: pt_q[2], last_of_run: 1'b1};
            for (int i = 0; i < 3; i++) begin
              anchor_q[i] <= pt_q[i];
            end
            pts_q <= 2'd1;
            state_q <= StIdle;
          end
        end
        StSquare: begin
          prod_q <= SumW'(sq_prod);
          acc_q <= (cnt_q == '0) ? '0 : acc_q + prod_q;
          if (cnt_q == CntW'(3)) begin
            sqv_q <= acc_q + prod_q;
            root_q <= '0;
            rem_q <= '0;
            cnt_q <= '0;
            state_q <= StRoot;
          end else begin
            cnt_q <= cnt_q + CntW'(1);
          end
        end
        StRoot: begin
          rem_q <= (rt_t >= rt_trial) ? (LenW+2)'(rt_t - rt_trial) : (LenW+2)'(rt_t);
          root_q <= root_d;
          sqv_q <= {sqv_q[SumW-3:0], 2'b00};
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(LenW - 1)) begin
            len_q <= root_d;
            dist_q <= DistW'(sp_eff);
            k_q <= '0;
            state_q <= StCheck;
          end
        end
        StCheck: begin
          if (((KW+1)'(k_q) < (KW+1)'(MaxSteps)) && (dist_q <= DistW'(len_q))) begin
            state_q <= StMul;
          end else if (rel_q) begin
            state_q <= StEnd;
          end else begin
            state_q <= StIdle;
          end
        end
        StMul: begin
          for (int i = 0; i < 3; i++) begin
            num_q[i] <= mag[i] * dist_q;
            drem_q[i] <= '0;
            quo_q[i] <= '0;
          end
          cnt_q <= '0;
          state_q <= StDiv;
        end
        StDiv: begin
          for (int i = 0; i < 3; i++) begin
            logic [LenW:0] t;
            t = {drem_q[i], num_q[i][ProdW-1]};
            if (t >= {1'b0, len_q}) begin
              drem_q[i] <= LenW'(t - {1'b0, len_q});
              quo_q[i] <= {quo_q[i][DistW-2:0], 1'b1};
            end else begin
              drem_q[i] <= t[LenW-1:0];
              quo_q[i] <= {quo_q[i][DistW-2:0], 1'b0};
            end
            num_q[i] <= {num_q[i][ProdW-2:0], 1'b0};
          end
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(ProdW - 1)) begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_q <= '{kind: sfsr_pkg::KindPoint, out_x: interp[0], out_y: interp[1],
                       out_z: interp[2], last_of_run: !rel_q && !more_steps};
            for (int i = 0; i < 3; i++) begin
              anchor_q[i] <= interp[i];
            end
            if (pts_q != 2'd2) begin
              pts_q <= pts_q + 2'd1;
            end
            k_q <= k_q + KW'(1);
            dist_q <= dist_next[DistW-1:0];
            state_q <= StCheck;
          end
        end
        StEnd: begin
          if (end_same) begin
            state_q <= StVerdict;
          end else if (out_free) begin
            out_valid_q <= 1'b1;
            out_q <= '{kind: sfsr_pkg::KindPoint, out_x: pt_q[0], out_y: pt_q[1],
                       out_z: pt_q[2], last_of_run: 1'b0};
            for (int i = 0; i < 3; i++) begin
              anchor_q[i] <= pt_q[i];
            end
            if (pts_q != 2'd2) begin
              pts_q <= pts_q + 2'd1;
            end
            state_q <= StVerdict;
          end
        end
        StVerdict: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_q <= '{kind: (pts_q == 2'd2) ? sfsr_pkg::KindComplete : sfsr_pkg::KindReject,
                       out_x: '0, out_y: '0, out_z: '0, last_of_run: 1'b1};
            pts_q <= 2'd0;
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end
endmodule

@@ sv/sfsr_checker.sv @@
// Port checker for the stroke resampler and its bind statement.
`timescale 1ns / 1ps
`include "stroke_fixed_step_resampler_assert.svh"
module sfsr_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input sfsr_pkg::rsp_t out_rsp_o
);
  `SFSR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_rsp_o), "Stalled result changed.")
  `SFSR_ASSERT(a_verdict_zero, clk_i, rst_ni, out_valid_o && out_rsp_o.kind != sfsr_pkg::KindPoint, out_rsp_o.out_x == '0 && out_rsp_o.out_y == '0 && out_rsp_o.out_z == '0, "Verdict carries a nonzero point.")
  `SFSR_ASSERT(a_verdict_last, clk_i, rst_ni, out_valid_o && out_rsp_o.kind != sfsr_pkg::KindPoint, out_rsp_o.last_of_run, "Verdict is not the last result.")
  `SFSR_ASSERT(a_kind_legal, clk_i, rst_ni, out_valid_o, out_rsp_o.kind == sfsr_pkg::KindPoint || out_rsp_o.kind == sfsr_pkg::KindComplete || out_rsp_o.kind == sfsr_pkg::KindReject, "Unknown result kind.")
endmodule

bind stroke_fixed_step_resampler sfsr_checker u_sfsr_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_rsp_o(out_rsp_o)
);

@@ tb/testbench.sv @@
// Self-checking testbench for the stroke fixed-step resampler.
`timescale 1ns / 1ps
module testbench;
  localparam int unsigned StallLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  sfsr_pkg::req_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  sfsr_pkg::rsp_t out_rsp_o;
  logic cfg_we_i = 1'b0;
  logic [sfsr_pkg::SpacingW-1:0] cfg_wdata_i = '0;

  always #6 clk_i = ~clk_i;

  stroke_fixed_step_resampler dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_req_i(in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o(out_rsp_o),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  sfsr_pkg::req_t pending_q[$];
  sfsr_pkg::rsp_t expected_q[$];
  int mismatches = 0;
  bit sending = 1'b0;

  logic [sfsr_pkg::SpacingW-1:0] spacing_mdl = sfsr_pkg::SpacingReset;
  longint anchor_x = 0, anchor_y = 0, anchor_z = 0;
  bit stroke_on = 1'b0;
  int stroke_points = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint sext(logic [sfsr_pkg::CoordW-1:0] v);
    return longint'(signed'(v));
  endfunction

  task automatic add_point(longint x, longint y, longint z);
    sfsr_pkg::rsp_t r;
    r = '0;
    r.kind = sfsr_pkg::KindPoint;
    r.out_x = x[sfsr_pkg::CoordW-1:0];
    r.out_y = y[sfsr_pkg::CoordW-1:0];
    r.out_z = z[sfsr_pkg::CoordW-1:0];
    expected_q.push_back(r);
    anchor_x = x;
    anchor_y = y;
    anchor_z = z;
    if (stroke_points < 2) stroke_points++;
  endtask

  task automatic follow_segment(longint px, longint py, longint pz, bit closing);
    longint dx, dy, dz, len, sp, step_pos, bx, by, bz;
    int k;
    dx = px - anchor_x;
    dy = py - anchor_y;
    dz = pz - anchor_z;
    len = longint'(int_sqrt(longint'(dx * dx + dy * dy + dz * dz)));
    sp = (spacing_mdl < sfsr_pkg::SpacingMin) ? longint'(sfsr_pkg::SpacingMin)
                                              : longint'(spacing_mdl);
    bx = anchor_x;
    by = anchor_y;
    bz = anchor_z;
    step_pos = sp;
    for (k = 0; k < sfsr_pkg::MaxStepsDefault && len > 0 && step_pos <= len; k++) begin
      add_point(bx + dx * step_pos / len, by + dy * step_pos / len,
                bz + dz * step_pos / len);
      step_pos += sp;
    end
    if (closing && (px != anchor_x || py != anchor_y || pz != anchor_z))
      add_point(px, py, pz);
  endtask

  task automatic predict_request(sfsr_pkg::req_t q);
    longint px, py, pz;
    int base;
    sfsr_pkg::rsp_t r;
    px = sext(q.point_x);
    py = sext(q.point_y);
    pz = sext(q.point_z);
    base = expected_q.size();
    case (q.mode)
      sfsr_pkg::ModePress: begin
        if (!stroke_on) begin
          stroke_on = 1'b1;
          stroke_points = 0;
          add_point(px, py, pz);
        end
      end
      sfsr_pkg::ModeDrag: begin
        if (stroke_on) begin
          if (stroke_points == 0) add_point(px, py, pz);
          else follow_segment(px, py, pz, 1'b0);
        end
      end
      sfsr_pkg::ModeRelease: begin
        if (stroke_on) begin
          stroke_on = 1'b0;
          if (stroke_points == 0) add_point(px, py, pz);
          else follow_segment(px, py, pz, 1'b1);
          r = '0;
          r.kind = (stroke_points >= 2) ? sfsr_pkg::KindComplete : sfsr_pkg::KindReject;
          expected_q.push_back(r);
          stroke_points = 0;
        end
      end
      default: begin
        stroke_on = 1'b0;
        stroke_points = 0;
      end
    endcase
    if (expected_q.size() > base) expected_q[expected_q.size() - 1].last_of_run = 1'b1;
  endtask

  // Request driver: one valid assignment per edge.
  int send_wait = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sending = 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_request(in_req_i);
        sending = 1'b0;
        send_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
      end
      if (!sending) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pending_q.size() > 0) begin
          in_req_i <= pending_q.pop_front();
          sending = 1'b1;
        end
      end
      in_valid_i <= sending;
    end
  end

  // Response monitor with random back-pressure.
  int take_wait = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    sfsr_pkg::rsp_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      take_wait = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response %p", out_rsp_o);
        end else begin
          want = expected_q.pop_front();
          if (out_rsp_o.kind !== want.kind || out_rsp_o.out_x !== want.out_x ||
              out_rsp_o.out_y !== want.out_y || out_rsp_o.out_z !== want.out_z ||
              out_rsp_o.last_of_run !== want.last_of_run) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p, got %p", want, out_rsp_o);
          end
        end
        take_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
      end else if (take_wait > 0) begin
        take_wait--;
      end
      out_ready_i <= (take_wait == 0);
    end
  end

  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic queue_request(logic [1:0] m, int x, int y, int z);
    sfsr_pkg::req_t q;
    q.mode = m;
    q.point_x = x[sfsr_pkg::CoordW-1:0];
    q.point_y = y[sfsr_pkg::CoordW-1:0];
    q.point_z = z[sfsr_pkg::CoordW-1:0];
    pending_q.push_back(q);
  endtask

  function automatic int jitter(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic wait_idle();
    wait (pending_q.size() == 0 && !sending && !in_valid_i && expected_q.size() == 0);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_spacing(logic [sfsr_pkg::SpacingW-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    spacing_mdl = v;
  endtask

  task automatic random_strokes(int count);
    int n, bx, by, bz, span, drags, d;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 9) == 0) begin
          bx = $urandom;
          by = $urandom;
          bz = $urandom;
        end else begin
          bx = jitter(1 << 16);
          by = jitter(1 << 16);
          bz = jitter(1 << 12);
        end
        span = (spacing_mdl < sfsr_pkg::SpacingMin) ? 4 * sfsr_pkg::SpacingMin
                                                    : 4 * int'(spacing_mdl);
        if (span > (1 << 22)) span = 1 << 22;
        queue_request(sfsr_pkg::ModePress, bx, by, bz);
        drags = $urandom_range(0, 4);
        for (d = 0; d < drags; d++) begin
          bx += jitter(span);
          by += jitter(span);
          bz += jitter(span / 4);
          queue_request(sfsr_pkg::ModeDrag, bx, by, bz);
        end
        if ($urandom_range(0, 5) == 0) queue_request(sfsr_pkg::ModeAbort, jitter(9), 0, 0);
        else queue_request(sfsr_pkg::ModeRelease, bx + jitter(span), by + jitter(span), bz);
        n += drags + 2;
      end else begin
        queue_request(2'($urandom), $urandom, $urandom, $urandom);
        n++;
      end
    end
  endtask

  localparam int CMax = (1 << 27) - 1;
  localparam int CMin = -(1 << 27);

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_request(sfsr_pkg::ModeDrag, 5, 5, 5);
    queue_request(sfsr_pkg::ModeRelease, 5, 5, 5);
    queue_request(sfsr_pkg::ModeAbort, 1, 2, 3);
    queue_request(sfsr_pkg::ModePress, 100, 200, 300);
    queue_request(sfsr_pkg::ModePress, 7, 7, 7);
    queue_request(sfsr_pkg::ModeRelease, 100, 200, 300);
    queue_request(sfsr_pkg::ModePress, 0, 0, 0);
    queue_request(sfsr_pkg::ModeRelease, 50, 0, 0);
    queue_request(sfsr_pkg::ModePress, CMin, CMin, CMin);
    queue_request(sfsr_pkg::ModeDrag, CMax, CMax, CMax);
    queue_request(sfsr_pkg::ModeRelease, CMax, CMax, CMax);
    queue_request(sfsr_pkg::ModePress, 0, 0, 0);
    queue_request(sfsr_pkg::ModeDrag, 0, 0, 0);
    queue_request(sfsr_pkg::ModeDrag, 1600, 0, 0);
    queue_request(sfsr_pkg::ModeDrag, 1600, -4000, 17);
    queue_request(sfsr_pkg::ModeAbort, 0, 0, 0);
    queue_request(sfsr_pkg::ModeDrag, 1, 1, 1);
    queue_request(sfsr_pkg::ModePress, -300, 40, -9);
    queue_request(sfsr_pkg::ModeDrag, 3000, 3000, -3000);
    queue_request(sfsr_pkg::ModeRelease, 3001, 3000, -3000);
    random_strokes(30);
    wait_idle();

    write_spacing(sfsr_pkg::SpacingMin);
    random_strokes(40);
    wait_idle();
    write_spacing('0);
    random_strokes(35);
    wait_idle();
    write_spacing('1);
    queue_request(sfsr_pkg::ModePress, CMax, CMin, 0);
    queue_request(sfsr_pkg::ModeRelease, CMin, CMax, 0);
    random_strokes(35);
    wait_idle();
    write_spacing(sfsr_pkg::SpacingW'($urandom_range(161, 20000)));
    random_strokes(40);
    wait_idle();
    write_spacing(sfsr_pkg::SpacingReset);
    random_strokes(20);

    wait (pending_q.size() == 0 && !sending && !in_valid_i && expected_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+sv
sv/sfsr_pkg.sv
sv/stroke_fixed_step_resampler.sv
sv/sfsr_checker.sv
tb/testbench.sv
